// ===== design/vie_pkg.sv =====
// Shared types and constants for the instruction executor.
`timescale 1ns / 1ps
package vie_pkg;
    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int SCR_PIX     = SCREEN_W * SCREEN_H;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SI_W        = $clog2(STACK_DEPTH);
    localparam logic [11:0] PC_RESET = 12'h200;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXEC  = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNIMPL = 2'd1,
        ST_STACK  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FETCH_HI, S_FETCH_LO, S_FETCH_WAIT, S_DECODE,
        S_CLS, S_ALU, S_ALU2, S_DRAW_RD, S_DRAW_WAIT, S_DRAW_PIX, S_DRAW_PIXW,
        S_DRAW_PIXWR, S_STORE, S_LOAD_RD, S_LOAD_WAIT, S_LOAD_WR, S_PIX_RD,
        S_PIX_WAIT, S_MEM_WR, S_RET, S_RET_WAIT, S_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic       clr_init;   // reset sweep of both memories
        logic       clr_step;
        logic       cap_in;     // capture input item
        logic       mem_wr_in;  // write data byte
        logic       fetch_hi;   // read mem[pc]
        logic       fetch_lo;   // read mem[pc+1], latch high byte
        logic       latch_op;   // latch low byte, pc+=2
        logic       exec;       // execute the decoded instruction
        logic       alu1;       // flag write, and Vx write for 8XY0-8XY4
        logic       alu2;       // Vx write
        logic       cls_start;
        logic       cls_step;
        logic       draw_start;
        logic       draw_rd;    // read sprite row
        logic       draw_lat;   // latch sprite row
        logic       pix_rd;     // read screen pixel for draw
        logic       pix_wr;     // xor pixel
        logic       bit_next;
        logic       row_next;
        logic       st_step;    // FX55 one byte
        logic       ld_rd;
        logic       ld_wr;
        logic       ld_next;
        logic       ret_rd;
        logic       ret_done;
        logic       call_push;
        logic       q_pix_rd;
        logic       q_pix_lat;
        logic       out_load;
        logic [1:0] status;
    } t_ctl;

    typedef struct packed {
        logic       clr_done;
        logic       cls_done;
        logic [1:0] cmd;
        logic [15:0] opcode;
        logic       sp_empty;
        logic       sp_full;
        logic       bit_set;    // current sprite bit is one
        logic       bit_last;
        logic       row_last;   // last row, or n == 0
        logic       idx_last;   // FX55/FX65 counter reached x
    } t_sts;
endpackage

// ===== design/vie_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/vie_datapath.sv =====
// Datapath: registers, stack, memory and screen RAMs, output register.
`timescale 1ns / 1ps
module vie_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vie_pkg::t_ctl  i_ctl,
    output vie_pkg::t_sts  o_sts,
    input  logic [1:0]     i_cmd,
    input  logic [11:0]    i_address,
    input  logic [7:0]     i_data,
    output logic [11:0]    o_pc,
    output logic [1:0]     o_status,
    output logic [7:0]     o_flag_reg,
    output logic           o_pixel
);
    import vie_pkg::*;

    logic [1:0]  r_cmd;
    logic [11:0] r_addr;
    logic [7:0]  r_data;
    logic [7:0]  r_v [16];
    logic [11:0] r_i;
    logic [11:0] r_pc;
    logic [11:0] r_stk [STACK_DEPTH];
    logic [SP_W-1:0] r_sp;
    logic [15:0] r_op;
    logic [11:0] r_clr;
    logic [7:0]  r_row_byte;
    logic [3:0]  r_row;
    logic [2:0]  r_bit;
    logic [3:0]  r_idx;
    logic        r_pix_out;

    logic        mem_we, scr_we;
    logic [11:0] mem_addr;
    logic [10:0] scr_addr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic        scr_wdata, scr_rdata;

    vie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata));
    vie_ram #(.WIDTH(1), .DEPTH(SCR_PIX)) u_scr (
        .i_clk(i_clk), .i_we(scr_we), .i_addr(scr_addr),
        .i_wdata(scr_wdata), .o_rdata(scr_rdata));

    logic [3:0] ox, oy, on;
    logic [7:0] nn, vx, vy;
    logic [5:0] px;
    logic [4:0] py;
    logic [11:0] pc2;
    assign ox = r_op[11:8];
    assign oy = r_op[7:4];
    assign on = r_op[3:0];
    assign nn = r_op[7:0];
    assign vx = r_v[ox];
    assign vy = r_v[oy];
    assign px = vx[5:0] + {3'd0, r_bit};
    assign py = vy[4:0] + {1'b0, r_row};
    assign pc2 = r_pc + 12'd2;

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc;
        mem_wdata = r_data;
        scr_we    = 1'b0;
        scr_addr  = {py, px};
        scr_wdata = ~scr_rdata;
        if (i_ctl.clr_step || i_ctl.cls_step) begin
            scr_we    = 1'b1;
            scr_addr  = r_clr[10:0];
            scr_wdata = 1'b0;
        end
        if (i_ctl.clr_step) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr;
            mem_wdata = 8'd0;
        end else if (i_ctl.mem_wr_in) begin
            mem_we    = 1'b1;
            mem_addr  = r_addr;
        end else if (i_ctl.fetch_lo) begin
            mem_addr  = r_pc + 12'd1;
        end else if (i_ctl.draw_rd) begin
            mem_addr  = r_i + {8'd0, r_row};
        end else if (i_ctl.st_step) begin
            mem_we    = 1'b1;
            mem_addr  = r_i + {8'd0, r_idx};
            mem_wdata = r_v[r_idx];
        end else if (i_ctl.ld_rd) begin
            mem_addr  = r_i + {8'd0, r_idx};
        end
        if (i_ctl.pix_wr) begin
            scr_we = 1'b1;
        end
        if (i_ctl.q_pix_rd) begin
            scr_addr = r_addr[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctl.clr_step || i_ctl.cls_step) begin
            r_clr <= r_clr + 12'd1;
        end else if (i_ctl.cls_start) begin
            r_clr <= '0;
        end
    end

    assign o_sts.clr_done = (r_clr == 12'(MEM_BYTES - 1));
    assign o_sts.cls_done = (r_clr[10:0] == 11'(SCR_PIX - 1));
    assign o_sts.cmd      = r_cmd;
    assign o_sts.opcode   = r_op;
    assign o_sts.sp_empty = (r_sp == '0);
    assign o_sts.sp_full  = (r_sp >= SP_W'(STACK_DEPTH));
    assign o_sts.bit_set  = r_row_byte[3'd7 - r_bit];
    assign o_sts.bit_last = (r_bit == 3'd7);
    assign o_sts.row_last = (r_row + 4'd1 >= on);
    assign o_sts.idx_last = (r_idx == ox);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_in) begin
            r_cmd  <= i_cmd;
            r_addr <= i_address;
            r_data <= i_data;
        end
        if (i_ctl.fetch_lo) r_op[15:8] <= mem_rdata;
        if (i_ctl.latch_op) r_op[7:0] <= mem_rdata;
        if (i_ctl.draw_lat) r_row_byte <= mem_rdata;
        if (i_ctl.draw_start) begin
            r_row <= '0;
            r_bit <= '0;
        end
        if (i_ctl.bit_next) r_bit <= r_bit + 3'd1;
        if (i_ctl.row_next) begin
            r_row <= r_row + 4'd1;
            r_bit <= '0;
        end
        if (i_ctl.exec) begin
            r_idx <= '0;
        end
        if (i_ctl.st_step || i_ctl.ld_next) r_idx <= r_idx + 4'd1;
        if (i_ctl.q_pix_lat) r_pix_out <= scr_rdata && (r_addr < 12'(SCR_PIX));
        if (i_ctl.cap_in) r_pix_out <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            r_i  <= '0;
            r_pc <= PC_RESET;
            r_sp <= '0;
        end else begin
            if (i_ctl.latch_op) r_pc <= pc2;
            if (i_ctl.exec) begin
                unique case (r_op[15:12])
                    4'h1: r_pc <= r_op[11:0];
                    4'h2: r_pc <= r_op[11:0];
                    4'h3: if (vx == nn) r_pc <= pc2;
                    4'h4: if (vx != nn) r_pc <= pc2;
                    4'h5: if (on == 4'd0 && vx == vy) r_pc <= pc2;
                    4'h6: r_v[ox] <= nn;
                    4'h7: r_v[ox] <= vx + nn;
                    4'h9: if (on == 4'd0 && vx != vy) r_pc <= pc2;
                    4'hA: r_i <= r_op[11:0];
                    4'hB: r_pc <= r_op[11:0] + {4'd0, r_v[0]};
                    4'hD: r_v[15] <= 8'd0;
                    4'hF: if (nn == 8'h1E) r_i <= r_i + {4'd0, vx};
                    default: ;
                endcase
            end
            if (i_ctl.call_push) begin
                r_stk[r_sp[SI_W-1:0]] <= r_pc;
                r_sp <= r_sp + SP_W'(1);
            end
            if (i_ctl.ret_rd) r_sp <= r_sp - SP_W'(1);
            if (i_ctl.ret_done) r_pc <= r_stk[r_sp[SI_W-1:0]];
            if (i_ctl.alu1) begin
                unique case (on)
                    4'h0: r_v[ox] <= vy;
                    4'h1: r_v[ox] <= vx | vy;
                    4'h2: r_v[ox] <= vx & vy;
                    4'h3: r_v[ox] <= vx ^ vy;
                    4'h4: begin
                        r_v[ox] <= vx + vy;
                        r_v[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
                    end
                    4'h5: r_v[15] <= {7'd0, vx >= vy};
                    4'h6: r_v[15] <= {7'd0, vx[0]};
                    4'h7: r_v[15] <= {7'd0, vy >= vx};
                    4'hE: r_v[15] <= {7'd0, vx[7]};
                    default: ;
                endcase
            end
            if (i_ctl.alu2) begin
                unique case (on)
                    4'h5: r_v[ox] <= vx - vy;
                    4'h6: r_v[ox] <= {1'b0, vx[7:1]};
                    4'h7: r_v[ox] <= vy - vx;
                    4'hE: r_v[ox] <= {vx[6:0], 1'b0};
                    default: ;
                endcase
            end
            if (i_ctl.pix_wr && scr_rdata) r_v[15] <= 8'd1;
            if (i_ctl.ld_wr) r_v[r_idx] <= mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_pc       <= r_pc;
            o_status   <= i_ctl.status;
            o_flag_reg <= r_v[15];
            o_pixel    <= r_pix_out;
        end
    end
endmodule

// ===== design/vie_controller.sv =====
// Controller state machine sequencing each command.
`timescale 1ns / 1ps
module vie_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  vie_pkg::t_sts  i_sts,
    output vie_pkg::t_ctl  o_ctl
);
    import vie_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic [1:0] r_st, n_st;
    logic [15:0] op;
    assign op = i_sts.opcode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ovalid <= 1'b0;
            r_st     <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_st     <= n_st;
        end
    end

    assign o_valid = r_ovalid;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_st     = r_st;
        n_ovalid = r_ovalid && !i_ready;
        o_ctl    = '0;
        o_ctl.status = r_st;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.cap_in = 1'b1;
                    n_st = ST_OK;
                    n_state = S_MEM_WR;
                end
            end
            S_MEM_WR: begin
                unique case (t_cmd'(i_sts.cmd))
                    CMD_WRITE: begin
                        o_ctl.mem_wr_in = 1'b1;
                        n_state = S_DONE;
                    end
                    CMD_EXEC:  n_state = S_FETCH_HI;
                    CMD_PIXEL: n_state = S_PIX_RD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_FETCH_HI: begin
                o_ctl.fetch_hi = 1'b1;
                n_state = S_FETCH_LO;
            end
            S_FETCH_LO: begin
                o_ctl.fetch_lo = 1'b1;
                n_state = S_FETCH_WAIT;
            end
            S_FETCH_WAIT: begin
                o_ctl.latch_op = 1'b1;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_DONE;
                priority if (op == 16'h00E0) begin
                    o_ctl.cls_start = 1'b1;
                    n_state = S_CLS;
                end else if (op == 16'h00EE) begin
                    if (i_sts.sp_empty) n_st = ST_STACK;
                    else begin
                        o_ctl.ret_rd = 1'b1;
                        n_state = S_RET;
                    end
                end else if (op[15:12] == 4'h0 || op[15:12] == 4'hC
                             || op[15:12] == 4'hE) begin
                    n_st = ST_UNIMPL;
                end else if ((op[15:12] == 4'h5 || op[15:12] == 4'h9)
                             && op[3:0] != 4'h0) begin
                    n_st = ST_UNIMPL;
                end else if (op[15:12] == 4'h2) begin
                    if (i_sts.sp_full) n_st = ST_STACK;
                    else begin
                        o_ctl.call_push = 1'b1;
                        o_ctl.exec = 1'b1;
                    end
                end else if (op[15:12] == 4'h8) begin
                    if ((op[3:0] <= 4'h7) || op[3:0] == 4'hE) begin
                        o_ctl.alu1 = 1'b1;
                        n_state = S_ALU2;
                    end else n_st = ST_UNIMPL;
                end else if (op[15:12] == 4'hD) begin
                    o_ctl.exec = 1'b1;
                    o_ctl.draw_start = 1'b1;
                    n_state = (op[3:0] == 4'd0) ? S_DONE : S_DRAW_RD;
                end else if (op[15:12] == 4'hF) begin
                    o_ctl.exec = 1'b1;
                    priority if (op[7:0] == 8'h1E) n_state = S_DONE;
                    else if (op[7:0] == 8'h55) n_state = S_STORE;
                    else if (op[7:0] == 8'h65) n_state = S_LOAD_RD;
                    else n_st = ST_UNIMPL;
                end else begin
                    o_ctl.exec = 1'b1;
                end
            end
            S_RET: n_state = S_RET_WAIT;
            S_RET_WAIT: begin
                o_ctl.ret_done = 1'b1;
                n_state = S_DONE;
            end
            S_CLS: begin
                o_ctl.cls_step = 1'b1;
                if (i_sts.cls_done) n_state = S_DONE;
            end
            S_ALU: n_state = S_ALU2;
            S_ALU2: begin
                o_ctl.alu2 = 1'b1;
                n_state = S_DONE;
            end
            S_DRAW_RD: begin
                o_ctl.draw_rd = 1'b1;
                n_state = S_DRAW_WAIT;
            end
            S_DRAW_WAIT: begin
                o_ctl.draw_lat = 1'b1;
                n_state = S_DRAW_PIX;
            end
            S_DRAW_PIX: begin
                if (i_sts.bit_set) n_state = S_DRAW_PIXW;
                else if (!i_sts.bit_last) o_ctl.bit_next = 1'b1;
                else if (!i_sts.row_last) begin
                    o_ctl.row_next = 1'b1;
                    n_state = S_DRAW_RD;
                end else n_state = S_DONE;
            end
            S_DRAW_PIXW: begin
                o_ctl.pix_rd = 1'b1;
                n_state = S_DRAW_PIXWR;
            end
            S_DRAW_PIXWR: begin
                o_ctl.pix_wr = 1'b1;
                if (!i_sts.bit_last) begin
                    o_ctl.bit_next = 1'b1;
                    n_state = S_DRAW_PIX;
                end else if (!i_sts.row_last) begin
                    o_ctl.row_next = 1'b1;
                    n_state = S_DRAW_RD;
                end else n_state = S_DONE;
            end
            S_STORE: begin
                o_ctl.st_step = 1'b1;
                if (i_sts.idx_last) n_state = S_DONE;
            end
            S_LOAD_RD: begin
                o_ctl.ld_rd = 1'b1;
                n_state = S_LOAD_WAIT;
            end
            S_LOAD_WAIT: begin
                // keep the address so the byte is still on the read port
                o_ctl.ld_rd = 1'b1;
                n_state = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                o_ctl.ld_wr = 1'b1;
                o_ctl.ld_next = 1'b1;
                n_state = i_sts.idx_last ? S_DONE : S_LOAD_RD;
            end
            S_PIX_RD: begin
                o_ctl.q_pix_rd = 1'b1;
                n_state = S_PIX_WAIT;
            end
            S_PIX_WAIT: begin
                o_ctl.q_pix_lat = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== design/vm_instruction_executor.sv =====
// Top level of the CHIP-8 style instruction executor.
`timescale 1ns / 1ps
// Usage:
//   Input channel i_valid/o_ready carries cmd, address and data. cmd 0
//   writes a memory byte, cmd 1 executes the instruction at pc, cmd 2
//   reads a screen pixel. Each transfer yields exactly one result on
//   o_valid/i_ready: pc, status, VF and pixel after the command.
//   One item at a time: o_ready is high only while idle, so a new item is
//   accepted only after the last one has finished. FX55 stores and FX65
//   loads one register per step, a sprite draw reads each row and then
//   reads and writes back each set bit, and a screen clear writes one
//   pixel per cycle through the screen RAM port.
//   After reset a clearing pass zeroes memory and screen; o_ready stays
//   low until it ends.
//   A result waits in the output register while the receiver stalls; the
//   next item is accepted meanwhile and its result is held back until the
//   register is free.
module vm_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_pc,
    output logic [1:0]  o_status,
    output logic [7:0]  o_flag_reg,
    output logic        o_pixel
);
    import vie_pkg::*;

    t_ctl ctl;
    t_sts sts;

    vie_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(sts), .o_ctl(ctl));

    vie_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_cmd(i_cmd), .i_address(i_address), .i_data(i_data),
        .o_pc(o_pc), .o_status(o_status), .o_flag_reg(o_flag_reg),
        .o_pixel(o_pixel));
endmodule

// ===== tb/vm_instruction_executor_test.sv =====
// Testbench for vm_instruction_executor: directed table, then random programs checked by a predictor.
`timescale 1ns / 1ps
module vm_instruction_executor_test;
    import vie_pkg::*;

    typedef struct {
        logic [11:0] pc;
        t_status     st;
        logic [7:0]  vf;
        logic        px;
    } core_res_t;

    typedef struct {
        t_cmd        cmd;
        logic [11:0] addr;
        logic [7:0]  data;
        bit          typed;
        core_res_t   res;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = CMD_WRITE;
    logic [11:0] i_address = '0;
    logic [7:0]  i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_pc;
    logic [1:0]  o_status;
    logic [7:0]  o_flag_reg;
    logic        o_pixel;

    // predictor state
    logic [7:0]  core_mem [MEM_BYTES];
    bit          core_scr [SCR_PIX];
    logic [7:0]  core_v [16];
    logic [11:0] core_i;
    logic [11:0] core_pc;
    logic [11:0] core_stk [STACK_DEPTH];
    int          core_sp;

    core_res_t   pending_res [$];
    dir_row_t    dir_tab [$];
    int          n_err = 0;
    int          n_sent = 0;
    bit          quiet = 1'b0;

    vm_instruction_executor dut (.*);

    always #4 i_clk = ~i_clk;

    task automatic report_err(string what, int got, int want);
        $display("%t: %s got %0h want %0h", $realtime, what, got, want);
        n_err++;
    endtask

    function automatic t_status exec_op();
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn;
        logic [8:0]  s;
        logic [7:0]  row_b;
        int          k;
        op = {core_mem[core_pc], core_mem[core_pc + 12'd1]};
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
        core_pc = core_pc + 12'd2;
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) begin
                    foreach (core_scr[j]) core_scr[j] = 1'b0;
                end else if (op == 16'h00EE) begin
                    if (core_sp == 0) return ST_STACK;
                    core_sp--;
                    core_pc = core_stk[core_sp];
                end else begin
                    return ST_UNIMPL;
                end
            end
            4'h1: core_pc = op[11:0];
            4'h2: begin
                if (core_sp >= STACK_DEPTH) return ST_STACK;
                core_stk[core_sp] = core_pc;
                core_sp++;
                core_pc = op[11:0];
            end
            4'h3: if (core_v[x] == nn) core_pc = core_pc + 12'd2;
            4'h4: if (core_v[x] != nn) core_pc = core_pc + 12'd2;
            4'h5: begin
                if (n != 0) return ST_UNIMPL;
                if (core_v[x] == core_v[y]) core_pc = core_pc + 12'd2;
            end
            4'h6: core_v[x] = nn;
            4'h7: core_v[x] = core_v[x] + nn;
            4'h8: begin
                case (n)
                    4'h0: core_v[x] = core_v[y];
                    4'h1: core_v[x] = core_v[x] | core_v[y];
                    4'h2: core_v[x] = core_v[x] & core_v[y];
                    4'h3: core_v[x] = core_v[x] ^ core_v[y];
                    4'h4: begin
                        s = {1'b0, core_v[x]} + {1'b0, core_v[y]};
                        core_v[x] = s[7:0];
                        core_v[15] = {7'd0, s[8]};
                    end
                    4'h5: begin
                        core_v[15] = {7'd0, core_v[x] >= core_v[y]};
                        core_v[x] = core_v[x] - core_v[y];
                    end
                    4'h6: begin
                        core_v[15] = {7'd0, core_v[x][0]};
                        core_v[x] = core_v[x] >> 1;
                    end
                    4'h7: begin
                        core_v[15] = {7'd0, core_v[y] >= core_v[x]};
                        core_v[x] = core_v[y] - core_v[x];
                    end
                    4'hE: begin
                        core_v[15] = {7'd0, core_v[x][7]};
                        core_v[x] = core_v[x] << 1;
                    end
                    default: return ST_UNIMPL;
                endcase
            end
            4'h9: begin
                if (n != 0) return ST_UNIMPL;
                if (core_v[x] != core_v[y]) core_pc = core_pc + 12'd2;
            end
            4'hA: core_i = op[11:0];
            4'hB: core_pc = op[11:0] + {4'd0, core_v[0]};
            4'hD: begin
                core_v[15] = 8'd0;
                for (int r = 0; r < n; r++) begin
                    row_b = core_mem[core_i + 12'(r)];
                    for (int b = 0; b < 8; b++) begin
                        if (row_b[7 - b]) begin
                            k = ((core_v[y] + r) % SCREEN_H) * SCREEN_W
                                + (core_v[x] + b) % SCREEN_W;
                            if (core_scr[k]) core_v[15] = 8'd1;
                            core_scr[k] = ~core_scr[k];
                        end
                    end
                end
            end
            4'hF: begin
                if (nn == 8'h1E) core_i = core_i + {4'd0, core_v[x]};
                else if (nn == 8'h55)
                    for (int j = 0; j <= x; j++) core_mem[core_i + 12'(j)] = core_v[j];
                else if (nn == 8'h65)
                    for (int j = 0; j <= x; j++) core_v[j] = core_mem[core_i + 12'(j)];
                else return ST_UNIMPL;
            end
            default: return ST_UNIMPL;
        endcase
        return ST_OK;
    endfunction

    function automatic core_res_t core_step(t_cmd cmd, logic [11:0] addr, logic [7:0] data);
        core_res_t r;
        r.st = ST_OK;
        r.px = 1'b0;
        case (cmd)
            CMD_WRITE: core_mem[addr] = data;
            CMD_EXEC:  r.st = exec_op();
            CMD_PIXEL: if (addr < SCR_PIX) r.px = core_scr[addr];
            default: ;
        endcase
        r.pc = core_pc;
        r.vf = core_v[15];
        return r;
    endfunction

    // one transfer on the input side; t_res overrides the prediction when typed
    task automatic send(t_cmd cmd, logic [11:0] addr, logic [7:0] data,
                        bit typed = 0,
                        core_res_t t_res = '{pc: '0, st: ST_OK, vf: '0, px: 1'b0});
        core_res_t r;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 34) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_cmd = cmd;
        i_address = addr;
        i_data = data;
        do @(posedge i_clk); while (!o_ready);
        r = core_step(cmd, addr, data);
        pending_res.push_back(typed ? t_res : r);
        n_sent++;
    endtask

    task automatic run_op(logic [15:0] op);
        send(CMD_WRITE, core_pc, op[15:8]);
        send(CMD_WRITE, core_pc + 12'd1, op[7:0]);
        send(CMD_EXEC, 12'($urandom), 8'($urandom));
    endtask

    function automatic logic [15:0] rand_op();
        logic [3:0] x, y;
        logic [7:0] nn;
        logic [3:0] alu_ops [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE, 4'hF};
        logic [7:0] f_ops [4] = '{8'h1E, 8'h55, 8'h65, 8'h07};
        x = 4'($urandom);
        y = 4'($urandom);
        nn = $urandom_range(1) ? core_v[x] : 8'($urandom);
        case ($urandom_range(19))
            0:  return $urandom_range(3) == 0 ? 16'h00E0 : {4'h6, x, nn};
            1:  return 16'h00EE;
            2:  return {4'h0, 12'($urandom)};
            3:  return {4'h1, 12'($urandom)};
            4, 5: return {4'h2, 12'($urandom)};
            6:  return {4'h3, x, nn};
            7:  return {4'h4, x, nn};
            8:  return {4'h5, x, y, $urandom_range(2) == 0 ? 4'($urandom) : 4'h0};
            9, 19: return {4'h6, x, 8'($urandom)};
            10: return {4'h7, x, 8'($urandom)};
            11, 12: return {4'h8, x, y,
                            $urandom_range(4) == 0 ? 4'($urandom) : alu_ops[$urandom_range(9)]};
            13: return {4'h9, x, y, $urandom_range(2) == 0 ? 4'($urandom) : 4'h0};
            14: return {4'hA, 12'($urandom)};
            15: return {4'hB, 12'($urandom)};
            16: return {4'hD, x, y, 4'($urandom)};
            17: return {4'hF, x, f_ops[$urandom_range(3)]};
            default: return {$urandom_range(1) ? 4'hC : 4'hE, 12'($urandom)};
        endcase
    endfunction

    function automatic void add_row(t_cmd c, logic [11:0] a, logic [7:0] d, bit typed = 0,
                                    logic [11:0] pc = 0, t_status st = ST_OK,
                                    logic [7:0] vf = 0, bit px = 0);
        dir_row_t row;
        row.cmd = c; row.addr = a; row.data = d; row.typed = typed;
        row.res = '{pc: pc, st: st, vf: vf, px: px};
        dir_tab.push_back(row);
    endfunction

    function automatic void add_op(logic [11:0] at, logic [15:0] op, bit typed = 0,
                                   logic [11:0] pc = 0, t_status st = ST_OK, logic [7:0] vf = 0);
        add_row(CMD_WRITE, at, op[15:8]);
        add_row(CMD_WRITE, at + 12'd1, op[7:0]);
        add_row(CMD_EXEC, 12'h000, 8'h00, typed, pc, st, vf);
    endfunction

    always @(negedge i_clk)
        i_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);

    always @(posedge i_clk) begin
        core_res_t w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_res.size() == 0) begin
                report_err("unexpected transfer pc", o_pc, 0);
            end else begin
                w = pending_res.pop_front();
                if (o_pc !== w.pc) report_err("pc", o_pc, w.pc);
                if (o_status !== w.st) report_err("status", o_status, w.st);
                if (o_flag_reg !== w.vf) report_err("vf", o_flag_reg, w.vf);
                if (o_pixel !== w.px) report_err("pixel", o_pixel, w.px);
            end
        end
    end

    initial begin
        #100ms;
        $display("vm_instruction_executor: mismatch");
        $finish;
    end

    initial begin
        foreach (core_mem[j]) core_mem[j] = 8'd0;
        foreach (core_scr[j]) core_scr[j] = 1'b0;
        foreach (core_v[j]) core_v[j] = 8'd0;
        core_i = '0;
        core_pc = PC_RESET;
        core_sp = 0;

        add_row(CMD_PIXEL, 12'd0, 8'hFF, 1, 12'h200);
        add_row(CMD_NONE, 12'hFFF, 8'hFF, 1, 12'h200);
        add_row(CMD_EXEC, 12'hABC, 8'h55, 1, 12'h202, ST_UNIMPL);
        add_op(12'h202, 16'h00EE, 1, 12'h204, ST_STACK);
        add_op(12'h204, 16'h60FF);
        add_op(12'h206, 16'h6101);
        add_op(12'h208, 16'h8014, 1, 12'h20A, ST_OK, 8'd1);
        add_op(12'h20A, 16'hA300);
        add_row(CMD_WRITE, 12'h300, 8'hFF);
        add_op(12'h20C, 16'hD011);
        add_op(12'h20E, 16'hD011, 1, 12'h210, ST_OK, 8'd1);
        add_op(12'h210, 16'h00E0);
        add_row(CMD_PIXEL, 12'hFFF, 8'h00, 1, 12'h212, ST_OK, 8'd1, 0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[j])
            send(dir_tab[j].cmd, dir_tab[j].addr, dir_tab[j].data,
                 dir_tab[j].typed, dir_tab[j].res);

        while (n_sent < 575) begin
            quiet = (n_sent >= 250 && n_sent < 350);
            if (n_sent >= 120 && n_sent < 124) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                wait (pending_res.size() == 0);
            end
            case ($urandom_range(9))
                0: send(CMD_WRITE, 12'($urandom), 8'($urandom));
                1: send(t_cmd'($urandom_range(1) ? CMD_PIXEL : CMD_NONE),
                        $urandom_range(1) ? 12'($urandom_range(SCR_PIX - 1)) : 12'($urandom),
                        8'($urandom));
                default: run_op(rand_op());
            endcase
        end
        @(negedge i_clk);
        i_valid = 1'b0;
        quiet = 1'b0;
        wait (pending_res.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_err == 0 && pending_res.size() == 0)
            $display("vm_instruction_executor: match");
        else
            $display("vm_instruction_executor: mismatch");
        $finish;
    end
endmodule
